### sv/nmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NDEF message parser package
// Shared types and constants: parse phases, word classes, status codes, the
// header flag positions and the result word carried to the output register.
// ----------------------------------------------------------------------------
package nmp_pkg;

   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd2097152;

   typedef enum logic [3:0] {
      PH_HEADER    = 4'd0,
      PH_TYPE_LEN  = 4'd1,
      PH_PAY_LEN   = 4'd2,
      PH_ID_LEN    = 4'd3,
      PH_TYPE      = 4'd4,
      PH_ID        = 4'd5,
      PH_PAYLOAD   = 4'd6,
      PH_AFTER_END = 4'd7,
      PH_FAILED    = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      CLS_HEADER   = 3'd0,
      CLS_TYPE_LEN = 3'd1,
      CLS_PAY_LEN  = 3'd2,
      CLS_ID_LEN   = 3'd3,
      CLS_TYPE     = 3'd4,
      CLS_ID       = 3'd5,
      CLS_PAYLOAD  = 3'd6,
      CLS_IGNORED  = 3'd7
   } byte_class_type;

   typedef enum logic [1:0] {
      STS_OK          = 2'd0,
      STS_NO_RECORD   = 2'd1,
      STS_END_MISSING = 2'd2
   } status_type;

   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   // Bit positions within the five header flags.
   localparam int FLAG_ME_BIT = 3;
   localparam int FLAG_SR_BIT = 1;
   localparam int FLAG_IL_BIT = 0;

   typedef struct packed {
      logic [7:0]     byte_value;
      byte_class_type byte_class;
      logic [7:0]     record_index;
      logic [2:0]     type_name_format;
      logic [4:0]     record_flags;
      logic           record_end;
      logic           parse_error;
      logic           trailing_ignored;
      logic           message_done;
      status_type     message_status;
   } result_type;

endpackage
`default_nettype wire

### sv/nmp_parse_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NDEF parser core
// Holds the record parse state and computes, for one input word, the tagged
// result word and the next state in a single pass.
// ----------------------------------------------------------------------------
module nmp_parse_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_en,
   input  wire logic               action,
   input  wire logic [7:0]         data_byte,
   input  wire logic [31:0]        max_payload_length,
   output nmp_pkg::result_type     result
);
   import nmp_pkg::*;

   phase_type   phase_ff,   phase_in;
   logic [4:0]  flags_ff,   flags_in;
   logic [2:0]  tnf_ff,     tnf_in;
   logic [7:0]  type_rem_ff, type_rem_in;
   logic [7:0]  id_rem_ff,  id_rem_in;
   logic [31:0] pay_rem_ff, pay_rem_in;
   logic [1:0]  len_cnt_ff, len_cnt_in;
   logic [7:0]  rec_done_ff, rec_done_in;
   logic        last_end_ff, last_end_in;
   logic        error_ff,   error_in;
   logic        trail_ff,   trail_in;

   logic           advance;
   logic           rec_end;
   byte_class_type cls;
   logic [31:0]    pay_shift;
   logic           end_error;
   status_type     status;

   assign pay_shift = {pay_rem_ff[23:0], data_byte};

   always_comb begin
      phase_in    = phase_ff;
      flags_in    = flags_ff;
      tnf_in      = tnf_ff;
      type_rem_in = type_rem_ff;
      id_rem_in   = id_rem_ff;
      pay_rem_in  = pay_rem_ff;
      len_cnt_in  = len_cnt_ff;
      rec_done_in = rec_done_ff;
      last_end_in = last_end_ff;
      error_in    = error_ff;
      trail_in    = trail_ff;
      advance     = 1'b0;
      rec_end     = 1'b0;
      cls         = CLS_IGNORED;

      case (phase_ff)
         PH_HEADER: begin
            cls         = CLS_HEADER;
            flags_in    = data_byte[7:3];
            tnf_in      = data_byte[2:0];
            type_rem_in = 8'd0;
            id_rem_in   = 8'd0;
            pay_rem_in  = 32'd0;
            len_cnt_in  = 2'd0;
            phase_in    = PH_TYPE_LEN;
         end
         PH_TYPE_LEN: begin
            cls         = CLS_TYPE_LEN;
            type_rem_in = data_byte;
            phase_in    = PH_PAY_LEN;
         end
         PH_PAY_LEN: begin
            cls        = CLS_PAY_LEN;
            pay_rem_in = pay_shift;
            if (flags_ff[FLAG_SR_BIT] || (len_cnt_ff == 2'd3)) begin
               len_cnt_in = 2'd0;
               if (pay_shift > max_payload_length) begin
                  error_in = 1'b1;
                  phase_in = PH_FAILED;
               end else if (flags_ff[FLAG_IL_BIT]) begin
                  phase_in = PH_ID_LEN;
               end else begin
                  id_rem_in = 8'd0;
                  advance   = 1'b1;
               end
            end else begin
               len_cnt_in = len_cnt_ff + 2'd1;
            end
         end
         PH_ID_LEN: begin
            cls       = CLS_ID_LEN;
            id_rem_in = data_byte;
            advance   = 1'b1;
         end
         PH_TYPE: begin
            cls         = CLS_TYPE;
            type_rem_in = type_rem_ff - 8'd1;
            advance     = (type_rem_in == 8'd0);
         end
         PH_ID: begin
            cls       = CLS_ID;
            id_rem_in = id_rem_ff - 8'd1;
            advance   = (id_rem_in == 8'd0);
         end
         PH_PAYLOAD: begin
            cls        = CLS_PAYLOAD;
            pay_rem_in = pay_rem_ff - 32'd1;
            advance    = (pay_rem_in == 32'd0);
         end
         PH_AFTER_END: begin
            cls      = CLS_IGNORED;
            trail_in = 1'b1;
         end
         default: begin
            cls      = CLS_IGNORED;
            phase_in = PH_FAILED;
         end
      endcase

      if (advance) begin
         if (type_rem_in != 8'd0) begin
            phase_in = PH_TYPE;
         end else if (id_rem_in != 8'd0) begin
            phase_in = PH_ID;
         end else if (pay_rem_in != 32'd0) begin
            phase_in = PH_PAYLOAD;
         end else begin
            rec_end     = 1'b1;
            last_end_in = flags_in[FLAG_ME_BIT];
            if (rec_done_ff != 8'hFF) begin
               rec_done_in = rec_done_ff + 8'd1;
            end
            phase_in = flags_in[FLAG_ME_BIT] ? PH_AFTER_END : PH_HEADER;
         end
      end

      // The end of a message reports on the current state and starts over.
      end_error = error_ff || !((phase_ff == PH_HEADER) || (phase_ff == PH_AFTER_END) ||
                                (phase_ff == PH_FAILED));
      if (rec_done_ff == 8'd0) begin
         status = STS_NO_RECORD;
      end else if (!last_end_ff) begin
         status = STS_END_MISSING;
      end else begin
         status = STS_OK;
      end

      if (action == ACTION_END) begin
         result.byte_value       = 8'd0;
         result.byte_class       = CLS_IGNORED;
         result.record_index     = rec_done_ff;
         result.type_name_format = tnf_ff;
         result.record_flags     = flags_ff;
         result.record_end       = 1'b0;
         result.parse_error      = end_error;
         result.trailing_ignored = trail_ff;
         result.message_done     = 1'b1;
         result.message_status   = status;
         phase_in    = PH_HEADER;
         flags_in    = 5'd0;
         tnf_in      = 3'd0;
         type_rem_in = 8'd0;
         id_rem_in   = 8'd0;
         pay_rem_in  = 32'd0;
         len_cnt_in  = 2'd0;
         rec_done_in = 8'd0;
         last_end_in = 1'b0;
         error_in    = 1'b0;
         trail_in    = 1'b0;
      end else begin
         result.byte_value       = data_byte;
         result.byte_class       = cls;
         result.record_index     = rec_done_ff;
         result.type_name_format = tnf_in;
         result.record_flags     = flags_in;
         result.record_end       = rec_end;
         result.parse_error      = error_in;
         result.trailing_ignored = trail_in;
         result.message_done     = 1'b0;
         result.message_status   = STS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         flags_ff    <= 5'd0;
         tnf_ff      <= 3'd0;
         type_rem_ff <= 8'd0;
         id_rem_ff   <= 8'd0;
         pay_rem_ff  <= 32'd0;
         len_cnt_ff  <= 2'd0;
         rec_done_ff <= 8'd0;
         last_end_ff <= 1'b0;
         error_ff    <= 1'b0;
         trail_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         flags_ff    <= flags_in;
         tnf_ff      <= tnf_in;
         type_rem_ff <= type_rem_in;
         id_rem_ff   <= id_rem_in;
         pay_rem_ff  <= pay_rem_in;
         len_cnt_ff  <= len_cnt_in;
         rec_done_ff <= rec_done_in;
         last_end_ff <= last_end_in;
         error_ff    <= error_in;
         trail_ff    <= trail_in;
      end
   end

endmodule
`default_nettype wire

### sv/ndef_message_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NDEF message parser unit
// Tags each byte of an NDEF message with its field class, record index, TNF
// and flags, and reports the message status on an end-of-message word.
//
// Usage: the request channel carries one word per message byte, or an end
// word (req_action high). Each accepted request word yields exactly one
// response word on the rsp_ channel, registered in the next cycle.
// Throughput is one word per cycle while req_stall is low; the parse state
// and the result are computed combinationally from the incoming word.
// When the receiver raises rsp_stall the response register holds its word and
// req_stall is raised in the same cycle, so no new word enters until the
// response is taken; the response register is refilled in the cycle it drains.
// The payload length limit is to be written through csr_write_enable and
// csr_write_data only while the unit is idle; the unit does not enforce this.
// Reset clears the parse state, empties the response register and sets the
// payload length limit to 2097152.
// ----------------------------------------------------------------------------
module ndef_message_parser_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_action,
   input  wire logic [7:0]             req_data_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_byte_value,
   output logic [2:0]                  rsp_byte_class,
   output logic [7:0]                  rsp_record_index,
   output logic [2:0]                  rsp_type_name_format,
   output logic [4:0]                  rsp_record_flags,
   output logic                        rsp_record_end,
   output logic                        rsp_parse_error,
   output logic                        rsp_trailing_ignored,
   output logic                        rsp_message_done,
   output logic [1:0]                  rsp_message_status,
   input  wire logic                   csr_write_enable,
   input  wire logic [31:0]            csr_write_data
);
   import nmp_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_word_ff;
   logic [31:0] max_len_ff;
   logic        req_take;
   result_type  step_result;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   nmp_parse_core u_core (
      .clock              (clock),
      .reset              (reset),
      .step_en            (req_take),
      .action             (req_action),
      .data_byte          (req_data_byte),
      .max_payload_length (max_len_ff),
      .result             (step_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         max_len_ff   <= MAX_PAYLOAD_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            max_len_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_word_ff <= step_result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_byte_value       = rsp_word_ff.byte_value;
   assign rsp_byte_class       = rsp_word_ff.byte_class;
   assign rsp_record_index     = rsp_word_ff.record_index;
   assign rsp_type_name_format = rsp_word_ff.type_name_format;
   assign rsp_record_flags     = rsp_word_ff.record_flags;
   assign rsp_record_end       = rsp_word_ff.record_end;
   assign rsp_parse_error      = rsp_word_ff.parse_error;
   assign rsp_trailing_ignored = rsp_word_ff.trailing_ignored;
   assign rsp_message_done     = rsp_word_ff.message_done;
   assign rsp_message_status   = rsp_word_ff.message_status;

   // Every accepted request word shows up as a response in the next cycle.
   a_take_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted word did not produce a response");

   // An end-of-message response carries no byte and never ends a record.
   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.message_done) |->
         (rsp_word_ff.byte_class == CLS_IGNORED && !rsp_word_ff.record_end))
      else $error("end response carries byte fields");

   // A completed record is never tagged as an ignored or header byte.
   a_end_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.record_end) |->
         (rsp_word_ff.byte_class != CLS_IGNORED && rsp_word_ff.byte_class != CLS_HEADER))
      else $error("record end on a non-record byte");

   // The status code is only nonzero on an end-of-message response.
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.message_done) |->
         (rsp_word_ff.message_status == STS_OK))
      else $error("status reported outside end of message");

endmodule
`default_nettype wire
